// ===== rtl/core/dsfd_pkg.sv =====
// Shared types, constants and helpers for the DSF to DoP / native DSD framer.
// No dependencies; every other file of the block but dsfd_ram refers to it by scoped name.
package dsfd_pkg;

  localparam int MAX_BLOCK_BYTES = 4096;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DOP_MODE    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

  // input operation codes
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_PREROLL = 1'b1;

  localparam logic [7:0] MARK_FIRST  = 8'h05;
  localparam logic [7:0] MARK_SECOND = 8'hFA;

  // one frame request handed from the front end to the back end
  typedef struct packed {
    logic        preroll;    // silent marker frame, store data unused
    logic        dop;        // DoP framing, else native 32-bit
    logic        marker_sel; // 0: MARK_FIRST, 1: MARK_SECOND
    logic        half;       // DoP: which byte pair of the stored word
    logic        block_end;
    logic [31:0] right_raw;  // right bytes as received, oldest in the top byte
  } frame_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [31:0] rev_bytes(input logic [31:0] w);
    return {rev8(w[31:24]), rev8(w[23:16]), rev8(w[15:8]), rev8(w[7:0])};
  endfunction

endpackage

// ===== rtl/core/dsfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dsfd_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dsfd_front.sv =====
// Front end: configuration registers, block-pair position, byte packing,
// left-store writes and frame requests. Depends on dsfd_pkg.
module dsfd_front #(
  parameter int MaxBlockBytes = dsfd_pkg::MAX_BLOCK_BYTES,
  localparam int WordDepth = MaxBlockBytes / 4,
  localparam int AddrW = (WordDepth > 1) ? $clog2(WordDepth) : 1,
  localparam int CntW = AddrW + 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [dsfd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [dsfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [7:0]                        data_byte_i,
  output logic                              ram_we_o,
  output logic [AddrW-1:0]                  ram_waddr_o,
  output logic [31:0]                       ram_wdata_o,
  output logic                              push_o,
  output dsfd_pkg::frame_t                  push_frame_o,
  output logic [AddrW-1:0]                  push_addr_o,
  input  logic                              q_full_i,
  input  logic                              q_valid_i
);

  localparam int NMax = WordDepth * 4;

  function automatic logic [CntW-1:0] block_last(input logic [12:0] cbb);
    int n;
    n = int'({cbb[12:2], 2'b00});
    if (n < 4) n = 4;
    if (n > NMax) n = NMax;
    return CntW'(n - 1);
  endfunction

  logic            dop_q, dop_d;
  logic [CntW-1:0] last_q, last_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            side_q, side_d;   // 0: left block, 1: right block
  logic [23:0]     hold_q, hold_d;
  logic            phase_q, phase_d;

  logic accept, is_last, frame_done, store_busy;

  // hold a left-word write while queued frames have yet to read the store
  assign store_busy = !side_q && (cnt_q[1:0] == 2'b11) && q_valid_i;
  assign in_stall_o = q_full_i || store_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_last    = (cnt_q == last_q);
  assign frame_done = dop_q ? cnt_q[0] : (cnt_q[1:0] == 2'b11);

  always_comb begin
    dop_d        = dop_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    side_d       = side_q;
    hold_d       = hold_q;
    phase_d      = phase_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = cnt_q[CntW-1:2];
    ram_wdata_o  = {hold_q, data_byte_i};
    push_o       = 1'b0;
    push_addr_o  = cnt_q[CntW-1:2];
    push_frame_o = '{preroll: 1'b0, dop: dop_q, marker_sel: phase_q, half: cnt_q[1],
                     block_end: is_last, right_raw: {hold_q, data_byte_i}};

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dsfd_pkg::CFG_DOP_MODE:    dop_d  = cfg_data_i[0];
        dsfd_pkg::CFG_BLOCK_BYTES: last_d = block_last(cfg_data_i);
        default: ;
      endcase
      // restart the block pair
      cnt_d  = '0;
      side_d = 1'b0;
      hold_d = '0;
    end else if (accept) begin
      if (op_i == dsfd_pkg::OP_PREROLL) begin
        if (dop_q) begin
          push_o               = 1'b1;
          push_frame_o.preroll = 1'b1;
          push_frame_o.block_end = 1'b0;
          phase_d              = !phase_q;
        end
      end else begin
        hold_d = {hold_q[15:0], data_byte_i};
        cnt_d  = is_last ? '0 : cnt_q + 1'b1;
        if (is_last) begin
          side_d = !side_q;
        end
        if (!side_q) begin
          ram_we_o = (cnt_q[1:0] == 2'b11);
        end else if (frame_done) begin
          push_o = 1'b1;
          if (dop_q) begin
            phase_d = !phase_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dop_q   <= 1'b0;
      last_q  <= block_last(13'd4096);
      cnt_q   <= '0;
      side_q  <= 1'b0;
      hold_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      dop_q   <= dop_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
      side_q  <= side_d;
      hold_q  <= hold_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/core/dsfd_queue.sv =====
// Four-entry request queue between front and back end.
// Depends on dsfd_pkg for the frame request type.
module dsfd_queue #(
  parameter int AddrW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dsfd_pkg::frame_t push_frame_i,
  input  logic [AddrW-1:0] push_addr_i,
  output logic             full_o,
  output logic             valid_o,
  output dsfd_pkg::frame_t frame_o,
  output logic [AddrW-1:0] addr_o,
  input  logic             pop_i
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  dsfd_pkg::frame_t frame_q [Depth];
  logic [AddrW-1:0] addr_q  [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    count_q;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign valid_o = (count_q != '0);
  assign frame_o = frame_q[rptr_q];
  assign addr_o  = addr_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      frame_q[wptr_q] <= push_frame_i;
      addr_q[wptr_q]  <= push_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/dsfd_back.sv =====
// Back end: left-store read, frame assembly and output register.
// Depends on dsfd_pkg for the frame type, markers and bit reversal.
module dsfd_back #(
  parameter int AddrW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  dsfd_pkg::frame_t q_frame_i,
  input  logic [AddrW-1:0] q_addr_i,
  output logic             q_pop_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [31:0]      ram_rdata_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      left_sample_o,
  output logic [31:0]      right_sample_o,
  output logic             block_end_o
);

  logic             r_valid_q;
  dsfd_pkg::frame_t r_frame_q;
  logic             o_valid_q;
  logic [31:0]      left_q, right_q;
  logic             end_q;

  logic        o_take, r_adv;
  logic [7:0]  marker;
  logic [15:0] left_pair;
  logic [31:0] left_d, right_d;

  assign o_take      = !o_valid_q || !out_stall_i;
  assign r_adv       = r_valid_q && o_take;
  assign q_pop_o     = q_valid_i && (!r_valid_q || r_adv);
  assign ram_re_o    = q_pop_o;
  assign ram_raddr_o = q_addr_i;

  always_comb begin
    marker    = r_frame_q.marker_sel ? dsfd_pkg::MARK_SECOND : dsfd_pkg::MARK_FIRST;
    left_pair = r_frame_q.half ? ram_rdata_i[15:0] : ram_rdata_i[31:16];
    priority if (r_frame_q.preroll) begin
      left_d  = {marker, 24'h000000};
      right_d = {marker, 24'h000000};
    end else if (r_frame_q.dop) begin
      left_d  = {marker, dsfd_pkg::rev8(left_pair[15:8]), dsfd_pkg::rev8(left_pair[7:0]),
                 8'h00};
      right_d = {marker, dsfd_pkg::rev8(r_frame_q.right_raw[15:8]),
                 dsfd_pkg::rev8(r_frame_q.right_raw[7:0]), 8'h00};
    end else begin
      left_d  = dsfd_pkg::rev_bytes(ram_rdata_i);
      right_d = dsfd_pkg::rev_bytes(r_frame_q.right_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      r_frame_q <= q_frame_i;
    end
    if (r_adv) begin
      left_q  <= left_d;
      right_q <= right_d;
      end_q   <= r_frame_q.block_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        r_valid_q <= 1'b1;
      end else if (r_adv) begin
        r_valid_q <= 1'b0;
      end
      if (o_take) begin
        o_valid_q <= r_valid_q;
      end
    end
  end

  assign out_valid_o    = o_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;
  assign block_end_o    = end_q;

endmodule

// ===== rtl/core/dsf_block_to_dop_or_native_dsd.sv =====
// Top level of the DSF block-pair to DoP / native DSD framer.
// Depends on dsfd_pkg, dsfd_front, dsfd_queue, dsfd_back and dsfd_ram.
//
// One byte is accepted every clock unless the input stalls. Left bytes are
// packed four to a word and written to a MaxBlockBytes/4 x 32 RAM, one write
// per four bytes; each frame completed by a right byte (every second byte in
// DoP, every fourth in native) reads one word from the second RAM port, so the
// store never limits the rate. Frame requests pass a four-entry queue, which
// separates byte intake from frame assembly, then the read stage and the
// output register. The input stalls when the queue is full, and for the byte
// that would write a left word while frames are still queued; with the output
// flowing the queue is empty by then unless a preroll was just queued, so only
// a stalled output otherwise holds the input. No clearing pass is needed after
// reset. Configuration writes are always ready and restart the block pair.
module dsf_block_to_dop_or_native_dsd #(
  parameter int MaxBlockBytes = dsfd_pkg::MAX_BLOCK_BYTES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dsfd_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [dsfd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [7:0]                       data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [31:0]                      left_sample_o,
  output logic [31:0]                      right_sample_o,
  output logic                             block_end_o
);

  localparam int WordDepth = MaxBlockBytes / 4;
  localparam int AddrW = (WordDepth > 1) ? $clog2(WordDepth) : 1;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;
  logic             push, q_full, q_valid, q_pop;
  dsfd_pkg::frame_t push_frame, q_frame;
  logic [AddrW-1:0] push_addr, q_addr;

  assign cfg_ready_o = 1'b1;

  dsfd_front #(
    .MaxBlockBytes(MaxBlockBytes)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .push_o       (push),
    .push_frame_o (push_frame),
    .push_addr_o  (push_addr),
    .q_full_i     (q_full),
    .q_valid_i    (q_valid)
  );

  dsfd_queue #(
    .AddrW(AddrW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_frame_i (push_frame),
    .push_addr_i  (push_addr),
    .full_o       (q_full),
    .valid_o      (q_valid),
    .frame_o      (q_frame),
    .addr_o       (q_addr),
    .pop_i        (q_pop)
  );

  dsfd_ram #(
    .Width(32),
    .Depth(WordDepth)
  ) u_left_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dsfd_back #(
    .AddrW(AddrW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_frame_i      (q_frame),
    .q_addr_i       (q_addr),
    .q_pop_o        (q_pop),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .block_end_o    (block_end_o)
  );

endmodule

// ===== verif/dsf_block_to_dop_or_native_dsd_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dsf_block_to_dop_or_native_dsd: DoP and native framing.
// Depends on dsfd_pkg and the RTL top level; has its own frame predictor and stimulus.
module dsf_block_to_dop_or_native_dsd_tb;

  localparam int STORE_BYTES  = dsfd_pkg::MAX_BLOCK_BYTES;
  localparam int RAND_ITEMS   = 1520;
  localparam int BIG_BLOCK    = 300;
  localparam int SETTLE       = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int PRINT_CAP    = 30;

  typedef struct packed {
    logic [31:0] l_word;
    logic [31:0] r_word;
    logic        last;
  } dsd_frame_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_SILENT, ROW_FRAME} row_kind_e;

  // sel is the register index for ROW_CFG and the op otherwise
  typedef struct packed {
    row_kind_e   kind;
    logic        sel;
    logic [12:0] value;
    logic [31:0] l_word;
    logic [31:0] r_word;
    logic        last;
  } step_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [dsfd_pkg::CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [dsfd_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = dsfd_pkg::OP_DATA;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] left_sample_o;
  logic [31:0] right_sample_o;
  logic        block_end_o;

  dsf_block_to_dop_or_native_dsd u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_sample_o (left_sample_o),
    .right_sample_o(right_sample_o),
    .block_end_o   (block_end_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor state and configuration
  logic [7:0]  left_img [0:STORE_BYTES-1];
  int          pair_pos = 0;
  logic [23:0] rhold = '0;
  logic        mark_odd = 1'b0;
  logic        cfg_dop = 1'b0;
  logic [12:0] cfg_blk = 13'd4096;

  dsd_frame_t  frames_due [$];
  dsd_frame_t  frame_want;
  int          mismatches = 0;
  int          frames_seen = 0;
  int          rand_items = 0;
  int          items_sent = 0;
  int          phases_run = 0;
  int          idle_run = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          steady = 1'b0;
  bit          big = 1'b0;

  // native preroll, native N=4 pair, DoP prerolls, DoP pair with a preroll inside,
  // then a mode change half way through the left block
  step_row_t directed_steps [0:25] = '{
    '{ROW_SILENT,  dsfd_pkg::OP_PREROLL,      13'h000, 32'h0, 32'h0, 1'b0},
    '{ROW_CFG,     dsfd_pkg::CFG_BLOCK_BYTES, 13'd5,   32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h000, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h0FF, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h001, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h080, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h0FF, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h000, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h080, 32'h0, 32'h0, 1'b0},
    '{ROW_FRAME,   dsfd_pkg::OP_DATA,         13'h001, 32'h00FF8001, 32'hFF000180, 1'b1},
    '{ROW_CFG,     dsfd_pkg::CFG_DOP_MODE,    13'd1,   32'h0, 32'h0, 1'b0},
    '{ROW_FRAME,   dsfd_pkg::OP_PREROLL,      13'h0C3, 32'h05000000, 32'h05000000, 1'b0},
    '{ROW_FRAME,   dsfd_pkg::OP_PREROLL,      13'h03C, 32'hFA000000, 32'hFA000000, 1'b0},
    '{ROW_CFG,     dsfd_pkg::CFG_BLOCK_BYTES, 13'd0,   32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h0A5, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h03C, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h00F, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h0F0, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h012, 32'h0, 32'h0, 1'b0},
    '{ROW_PREDICT, dsfd_pkg::OP_DATA,         13'h034, 32'h0, 32'h0, 1'b0},
    '{ROW_PREDICT, dsfd_pkg::OP_PREROLL,      13'h000, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h056, 32'h0, 32'h0, 1'b0},
    '{ROW_PREDICT, dsfd_pkg::OP_DATA,         13'h078, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h011, 32'h0, 32'h0, 1'b0},
    '{ROW_SILENT,  dsfd_pkg::OP_DATA,         13'h022, 32'h0, 32'h0, 1'b0},
    '{ROW_CFG,     dsfd_pkg::CFG_DOP_MODE,    13'd0,   32'h0, 32'h0, 1'b0}
  };

  function automatic logic [7:0] flip8(input logic [7:0] v);
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  endfunction

  function automatic int blk_eff();
    int n;
    n = int'(cfg_blk) & ~3;
    if (n < 4) n = 4;
    if (n > STORE_BYTES) n = STORE_BYTES;
    return n;
  endfunction

  function automatic logic [7:0] marker_now();
    return mark_odd ? dsfd_pkg::MARK_SECOND : dsfd_pkg::MARK_FIRST;
  endfunction

  task automatic predict_frame(input logic op, input logic [7:0] b,
                               output bit made, output dsd_frame_t f);
    int n;
    int pos;
    int j;
    int fsz;
    logic [7:0] m;
    made = 1'b0;
    f = '0;
    n = blk_eff();
    if (op == dsfd_pkg::OP_PREROLL) begin
      if (cfg_dop) begin
        m = marker_now();
        f = '{{m, 24'h0}, {m, 24'h0}, 1'b0};
        made = 1'b1;
        mark_odd = ~mark_odd;
      end
      return;
    end
    pos = (pair_pos >= 2 * n) ? 0 : pair_pos;
    if (pos < n) begin
      left_img[pos] = b;
      pair_pos = pos + 1;
      return;
    end
    j = pos - n;
    f.last = (j == n - 1);
    pair_pos = f.last ? 0 : pos + 1;
    fsz = cfg_dop ? 2 : 4;
    if (j % fsz == fsz - 1) begin
      made = 1'b1;
      if (cfg_dop) begin
        m = marker_now();
        f.l_word = {m, flip8(left_img[j-1]), flip8(left_img[j]), 8'h00};
        f.r_word = {m, flip8(rhold[7:0]), flip8(b), 8'h00};
        mark_odd = ~mark_odd;
      end else begin
        f.l_word = {flip8(left_img[j-3]), flip8(left_img[j-2]),
                    flip8(left_img[j-1]), flip8(left_img[j])};
        f.r_word = {flip8(rhold[23:16]), flip8(rhold[15:8]), flip8(rhold[7:0]), flip8(b)};
      end
    end
    rhold = {rhold[15:0], b};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t mismatch on frame %0d, %s: got %h, want %h",
               $realtime, frames_seen, what, got, want);
  endtask

  task automatic check_frame();
    frames_seen++;
    if (frames_due.size() == 0) begin
      report_mismatch("frame with none due", left_sample_o, 32'h0);
    end else begin
      frame_want = frames_due.pop_front();
      if (left_sample_o !== frame_want.l_word)
        report_mismatch("left_sample", left_sample_o, frame_want.l_word);
      if (right_sample_o !== frame_want.r_word)
        report_mismatch("right_sample", right_sample_o, frame_want.r_word);
      if (block_end_o !== frame_want.last)
        report_mismatch("block_end", {31'h0, block_end_o}, {31'h0, frame_want.last});
    end
  endtask

  // sink side: check, then choose the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_frame();
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d frames still due",
               idle_run, frames_due.size());
      $display("FAIL dsf_block_to_dop_or_native_dsd");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // offer one request and hold it until taken
  task automatic offer(input logic op, input logic [7:0] b);
    if (!steady && $urandom_range(99) < 40) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic feed(input logic op, input logic [7:0] b);
    bit made;
    dsd_frame_t f;
    offer(op, b);
    predict_frame(op, b, made, f);
    if (made) frames_due.push_back(f);
    rand_items++;
  endtask

  // wait for every frame, then let left bytes still in flight drain
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [dsfd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      dsfd_pkg::CFG_DOP_MODE:    cfg_dop = val[0];
      dsfd_pkg::CFG_BLOCK_BYTES: cfg_blk = val;
      default: ;
    endcase
    pair_pos = 0;
    rhold = '0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [12:0] pick_block_bytes();
    int r;
    r = $urandom_range(99);
    if (r < 12) return 13'($urandom_range(0, 3));
    if (r < 20) return 13'd4;
    return 13'($urandom_range(5, 40));
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // one phase: new settings, whole block pairs, sometimes a broken tail
  task automatic run_phase(input int ph);
    int n;
    int pairs;
    drain_and_settle();
    big = (ph == 2);
    if (big) begin
      cfg_write(dsfd_pkg::CFG_DOP_MODE, 13'd1);
      cfg_write(dsfd_pkg::CFG_BLOCK_BYTES, 13'(BIG_BLOCK));
    end else begin
      if (ph < 2 || $urandom_range(1)) cfg_write(dsfd_pkg::CFG_DOP_MODE, 13'($urandom_range(1)));
      if (ph <= 3 || $urandom_range(3) != 0) cfg_write(dsfd_pkg::CFG_BLOCK_BYTES, pick_block_bytes());
    end
    steady = (ph == 1);
    if (ph == 4) hold_req <= 1'b1;
    n = blk_eff();
    pairs = big ? 1 : $urandom_range(1, 3);
    repeat (pairs) begin
      for (int k = 0; k < 2 * n; k++) begin
        if (!big && $urandom_range(99) < 4) feed(dsfd_pkg::OP_PREROLL, 8'($urandom_range(255)));
        feed(dsfd_pkg::OP_DATA, pick_byte());
      end
    end
    if (!big && $urandom_range(99) < 30)
      repeat ($urandom_range(1, 2 * n - 1)) feed(dsfd_pkg::OP_DATA, pick_byte());
    phases_run++;
  endtask

  initial begin
    step_row_t row;
    bit made;
    dsd_frame_t f;
    int ph;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(directed_steps); i++) begin
      row = directed_steps[i];
      if (row.kind == ROW_CFG) begin
        drain_and_settle();
        cfg_write(row.sel, row.value);
      end else begin
        offer(row.sel, row.value[7:0]);
        predict_frame(row.sel, row.value[7:0], made, f);
        case (row.kind)
          ROW_PREDICT: if (made) frames_due.push_back(f);
          ROW_FRAME:   frames_due.push_back('{row.l_word, row.r_word, row.last});
          default: ;
        endcase
      end
    end

    ph = 0;
    while (rand_items < RAND_ITEMS) begin
      run_phase(ph);
      ph++;
    end
    big = 1'b0;

    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("ran %0d requests (%0d random) over %0d phases, %0d frames checked",
             items_sent, rand_items, phases_run, frames_seen);
    $display("both framings, block sizes from clamped-low to a 300-byte DoP pair, prerolls");
    if (mismatches == 0) begin
      $display("PASS dsf_block_to_dop_or_native_dsd");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL dsf_block_to_dop_or_native_dsd");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dsfd_pkg.sv
rtl/core/dsfd_ram.sv
rtl/core/dsfd_front.sv
rtl/core/dsfd_queue.sv
rtl/core/dsfd_back.sv
rtl/core/dsf_block_to_dop_or_native_dsd.sv
verif/dsf_block_to_dop_or_native_dsd_tb.sv
